@@ design/ihex_pkg.sv @@
package ihex_pkg;

	// Largest data field a record may carry.
	localparam int MAX_DATA_BYTES = 255;

	// The data field is held as 32-bit words, already padded with 0xFF.
	localparam int RAM_DEPTH = (MAX_DATA_BYTES + 3) / 4;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int WCNT_W    = $clog2(RAM_DEPTH + 1);

	localparam int CFG_IDX_W = 8;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_APP_BASE     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_APP_END      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROTECT_BASE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROTECT_END  = 8'd3;

	// Record types.
	localparam logic [7:0] REC_DATA    = 8'h00;
	localparam logic [7:0] REC_EOF     = 8'h01;
	localparam logic [7:0] REC_SEGMENT = 8'h02;
	localparam logic [7:0] REC_LINEAR  = 8'h04;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_CHECKSUM = 2'd1,
		STAT_TYPE     = 2'd2,
		STAT_WINDOW   = 2'd3
	} status_t;

	// What the output register loads in a cycle.
	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_STATUS,
		OUT_MID,
		OUT_FINAL
	} out_op_t;

	typedef struct packed {
		logic    take_byte;
		logic    calc_addr;
		logic    start_scan;
		logic    step;
		logic    load_pend;
		logic    apply_base;
		out_op_t out_op;
		status_t out_code;
	} ihex_cmd_t;

	typedef struct packed {
		logic       rec_end;
		logic       sum_bad;
		logic [7:0] kind;
		logic       win_bad;
		logic       prot_hit;
		logic       scan_end;
		logic       pend_valid;
		logic       out_free;
	} ihex_stat_t;

endpackage

@@ design/ihex_if.sv @@
// Record byte stream.
interface ihex_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rec_byte;

	modport source (output valid, output rec_byte, input ready);
	modport sink (input valid, input rec_byte, output ready);
endinterface

// Flash word results.
interface ihex_word_if;
	logic        valid;
	logic        ready;
	logic        write_valid;
	logic [31:0] word_address;
	logic [31:0] word_data;
	logic [1:0]  status;
	logic [7:0]  record_kind;
	logic        last;

	modport source (output valid, output write_valid, output word_address,
		output word_data, output status, output record_kind, output last, input ready);
	modport sink (input valid, input write_valid, input word_address,
		input word_data, input status, input record_kind, input last, output ready);
endinterface

// Configuration write channel.
interface ihex_cfg_if;
	import ihex_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/ihex_ram.sv @@
module ihex_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end

endmodule

@@ design/ihex_ctrl.sv @@
module ihex_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  ihex_pkg::ihex_stat_t stat,
	output ihex_pkg::ihex_cmd_t  cmd
);
	import ihex_pkg::*;

	typedef enum logic [2:0] {
		ST_RECV,
		ST_ADDR,
		ST_CHECK,
		ST_RESULT,
		ST_SCAN,
		ST_FETCH,
		ST_DONE
	} state_t;

	state_t  state_q;
	status_t code_q;
	logic    is_base;

	assign is_base = (stat.kind == REC_EOF) || (stat.kind == REC_SEGMENT) ||
		(stat.kind == REC_LINEAR);

	// Commands to the datapath, decoded from the state and its status.
	always_comb begin
		cmd = '0;
		cmd.out_op = OUT_NONE;
		cmd.out_code = STAT_OK;
		case (state_q)
			ST_RECV: begin
				cmd.take_byte = 1'b1;
			end
			ST_ADDR: begin
				cmd.calc_addr = 1'b1;
			end
			ST_CHECK: begin
				cmd.start_scan = !stat.sum_bad && (stat.kind == REC_DATA) && !stat.win_bad;
				cmd.apply_base = !stat.sum_bad && is_base;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.out_op = OUT_STATUS;
					cmd.out_code = code_q;
				end
			end
			ST_SCAN: begin
				cmd.step = !stat.scan_end && stat.prot_hit;
			end
			ST_FETCH: begin
				if (!stat.pend_valid || stat.out_free) begin
					cmd.load_pend = 1'b1;
					cmd.step = 1'b1;
					if (stat.pend_valid) begin
						cmd.out_op = OUT_MID;
					end
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_op = OUT_FINAL;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and the status code of a single-result record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
			code_q <= STAT_OK;
		end else begin
			case (state_q)
				ST_RECV: begin
					if (stat.rec_end) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (stat.sum_bad) begin
						code_q <= STAT_CHECKSUM;
						state_q <= ST_RESULT;
					end else if (stat.kind == REC_DATA) begin
						if (stat.win_bad) begin
							code_q <= STAT_WINDOW;
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_SCAN;
						end
					end else if (is_base) begin
						code_q <= STAT_OK;
						state_q <= ST_RESULT;
					end else begin
						code_q <= STAT_TYPE;
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (stat.out_free) begin
						state_q <= ST_RECV;
					end
				end
				ST_SCAN: begin
					if (stat.scan_end) begin
						state_q <= ST_DONE;
					end else if (!stat.prot_hit) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (!stat.pend_valid || stat.out_free) begin
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					if (stat.out_free) begin
						state_q <= ST_RECV;
					end
				end
				default: begin
					state_q <= ST_RECV;
				end
			endcase
		end
	end

endmodule

@@ design/ihex_datapath.sv @@
module ihex_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ihex_pkg::ihex_cmd_t cmd,
	output ihex_pkg::ihex_stat_t stat,
	ihex_byte_if.sink           rec_in,
	ihex_word_if.source         rec_out,
	ihex_cfg_if.sink            cfg
);
	import ihex_pkg::*;

	// Configuration registers.
	logic [31:0] app_base_q;
	logic [31:0] app_end_q;
	logic [31:0] prot_base_q;
	logic [31:0] prot_end_q;

	// Record intake.
	logic [8:0]  pos_q;
	logic [7:0]  len_q;
	logic [7:0]  type_q;
	logic [15:0] off_q;
	logic [7:0]  sum_q;
	logic [7:0]  b0_q;
	logic [7:0]  b1_q;
	logic [31:0] asm_q;
	logic [31:0] asm_next;
	logic [7:0]  didx;
	logic        in_acc;
	logic        finishing;
	logic [7:0]  b;

	// Address bases and word scan.
	logic [19:0]       seg_q;
	logic [15:0]       lin_q;
	logic [31:0]       addr_q;
	logic [31:0]       cur_q;
	logic [WCNT_W-1:0] w_q;
	logic [8:0]        nw9;
	logic [WCNT_W-1:0] nwords;
	logic [32:0]       top;

	// Pending word and output register.
	logic        pend_valid_q;
	logic [31:0] pend_addr_q;
	logic [31:0] pend_data_q;
	logic        out_valid_q;
	logic        out_write_q;
	logic [31:0] out_addr_q;
	logic [31:0] out_data_q;
	status_t     out_status_q;
	logic [7:0]  out_kind_q;
	logic        out_last_q;

	// Data word memory.
	logic              ram_we;
	logic [RAM_AW-1:0] ram_wa;
	logic [31:0]       ram_rd;

	assign b = rec_in.rec_byte;
	assign rec_in.ready = cmd.take_byte;
	assign in_acc = rec_in.valid && cmd.take_byte;
	assign cfg.ready = 1'b1;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_base_q <= '0;
			app_end_q <= ALL_ONES;
			prot_base_q <= ALL_ONES;
			prot_end_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_APP_BASE: app_base_q <= cfg.data;
				REG_APP_END: app_end_q <= cfg.data;
				REG_PROTECT_BASE: prot_base_q <= cfg.data;
				REG_PROTECT_END: prot_end_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Byte framing: the checksum byte sits one past the data field.
	assign didx = pos_q[7:0] - 8'd4;
	assign finishing = (pos_q >= ({1'b0, len_q} + 9'd4));

	// Fill the current word lane by lane, starting from all ones.
	always_comb begin
		asm_next = (didx[1:0] == 2'd0) ? ALL_ONES : asm_q;
		asm_next[8 * didx[1:0] +: 8] = b;
	end

	assign ram_we = in_acc && (pos_q >= 9'd4) && !finishing &&
		((didx[1:0] == 2'd3) || (didx == len_q - 8'd1)) &&
		(9'(didx >> 2) < 9'(RAM_DEPTH));
	assign ram_wa = RAM_AW'(didx >> 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
			type_q <= '0;
			off_q <= '0;
			sum_q <= '0;
			b0_q <= '0;
			b1_q <= '0;
		end else if (in_acc) begin
			if (pos_q == 9'd0) begin
				len_q <= b;
				sum_q <= b;
				b0_q <= '0;
				b1_q <= '0;
				pos_q <= 9'd1;
			end else if (pos_q == 9'd1) begin
				off_q[15:8] <= b;
				sum_q <= sum_q + b;
				pos_q <= 9'd2;
			end else if (pos_q == 9'd2) begin
				off_q[7:0] <= b;
				sum_q <= sum_q + b;
				pos_q <= 9'd3;
			end else if (pos_q == 9'd3) begin
				type_q <= b;
				sum_q <= sum_q + b;
				pos_q <= 9'd4;
			end else if (!finishing) begin
				if (didx == 8'd0) begin
					b0_q <= b;
				end
				if (didx == 8'd1) begin
					b1_q <= b;
				end
				sum_q <= sum_q + b;
				pos_q <= pos_q + 9'd1;
			end else begin
				sum_q <= sum_q + b;
				pos_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (pos_q >= 9'd4) && !finishing) begin
			asm_q <= asm_next;
		end
	end

	ihex_ram #(
		.WIDTH(32),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.wa(ram_wa),
		.wd(asm_next),
		.ra(w_q[RAM_AW-1:0]),
		.rd(ram_rd)
	);

	// Address bases, updated by good base and end-of-file records.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
			lin_q <= '0;
		end else if (cmd.apply_base) begin
			case (type_q)
				REC_EOF: begin
					seg_q <= '0;
					lin_q <= '0;
				end
				REC_SEGMENT: begin
					seg_q <= {b0_q, b1_q, 4'h0};
					lin_q <= '0;
				end
				REC_LINEAR: begin
					lin_q <= {b0_q, b1_q};
					seg_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Physical address of the record, then the word walk.
	always_ff @(posedge clk) begin
		if (cmd.calc_addr) begin
			addr_q <= {16'h0, off_q} + {lin_q, 16'h0} + {12'h0, seg_q};
		end
		if (cmd.start_scan) begin
			cur_q <= addr_q;
			w_q <= '0;
		end else if (cmd.step) begin
			cur_q <= cur_q + 32'd4;
			w_q <= w_q + WCNT_W'(1);
		end
	end

	assign nw9 = ({1'b0, len_q} + 9'd3) >> 2;
	assign nwords = WCNT_W'(nw9);
	assign top = {1'b0, addr_q} + {25'h0, len_q} - 33'd1;

	// Pending word: held back until it is known whether it is the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.start_scan || cmd.out_op == OUT_FINAL) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.load_pend) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pend) begin
			pend_addr_q <= cur_q;
			pend_data_q <= ram_rd;
		end
	end

	// Output register; the controller loads it only when it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_op != OUT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (rec_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The record type is captured with the item, as the next record may be taken in
	// while this one waits.
	always_ff @(posedge clk) begin
		case (cmd.out_op)
			OUT_STATUS: begin
				out_write_q <= 1'b0;
				out_addr_q <= '0;
				out_data_q <= '0;
				out_status_q <= cmd.out_code;
				out_kind_q <= type_q;
				out_last_q <= 1'b1;
			end
			OUT_MID: begin
				out_write_q <= 1'b1;
				out_addr_q <= pend_addr_q;
				out_data_q <= pend_data_q;
				out_status_q <= STAT_OK;
				out_kind_q <= type_q;
				out_last_q <= 1'b0;
			end
			OUT_FINAL: begin
				out_write_q <= pend_valid_q;
				out_addr_q <= pend_valid_q ? pend_addr_q : 32'h0;
				out_data_q <= pend_valid_q ? pend_data_q : 32'h0;
				out_status_q <= STAT_OK;
				out_kind_q <= type_q;
				out_last_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign rec_out.valid = out_valid_q;
	assign rec_out.write_valid = out_write_q;
	assign rec_out.word_address = out_addr_q;
	assign rec_out.word_data = out_data_q;
	assign rec_out.status = out_status_q;
	assign rec_out.record_kind = out_kind_q;
	assign rec_out.last = out_last_q;

	// Status to the controller.
	assign stat.rec_end = in_acc && (pos_q >= 9'd4) && finishing;
	assign stat.sum_bad = (sum_q != 8'd0) || ({1'b0, len_q} > 9'(MAX_DATA_BYTES));
	assign stat.kind = type_q;
	assign stat.win_bad = (addr_q < app_base_q) ||
		((len_q != 8'd0) && (top > {1'b0, app_end_q}));
	assign stat.prot_hit = (cur_q >= prot_base_q) && (cur_q <= prot_end_q);
	assign stat.scan_end = (w_q == nwords);
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free = !out_valid_q || rec_out.ready;

endmodule

@@ design/intel_hex_record_loader_unit.sv @@
// Intel HEX record loader.
// rec_in takes the binary record stream, one byte per item: length, offset high,
// offset low, type, data bytes, checksum. rec_out gives one item per flash word
// written (little-endian, missing trailing bytes read as 0xFF), or a single item
// without a write for base, end-of-file, empty, fully protected or rejected
// records; the final item of each record has last set. cfg writes the window
// registers by index. Bytes are taken one per cycle while a record is being
// framed. After the checksum byte the loader stops taking bytes: it works out the
// address, checks the window, then loads the single item of a base, end-of-file
// or rejected record once the output register is free. A data record instead
// walks its words: a protected word is skipped, a word that is emitted is read
// from the word memory into a pending register, and the walk closes by loading
// the final item. The word walk is set by the single read port of the word
// memory. A finished item waits in an output register; while rec_out stalls,
// the loader still takes the bytes of the next record, and it holds at the end
// of that record until the register frees. Reset clears the framing position,
// the address bases and the output register, and sets the windows to their
// defaults.
module intel_hex_record_loader_unit (
	input logic         clk,
	input logic         arst_n,
	ihex_byte_if.sink   rec_in,
	ihex_word_if.source rec_out,
	ihex_cfg_if.sink    cfg
);
	import ihex_pkg::*;

	ihex_cmd_t  cmd;
	ihex_stat_t stat;

	ihex_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.cmd(cmd)
	);

	ihex_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.rec_in(rec_in),
		.rec_out(rec_out),
		.cfg(cfg)
	);

endmodule

@@ bench/intel_hex_record_loader_unit_test.sv @@
`timescale 1ns / 1ps

module intel_hex_record_loader_unit_test;
	import ihex_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 12;

	// One flash word result as it leaves the loader.
	typedef struct {
		logic        write_valid;
		logic [31:0] word_address;
		logic [31:0] word_data;
		status_t     status;
		logic [7:0]  record_kind;
		logic        last;
	} flash_word_t;

	typedef logic [7:0] byte_q_t[$];

	// Tracks the record framing and the address bases, and holds the words still owed.
	class flash_word_tracker;
		logic [31:0] win_lo, win_hi, prot_lo, prot_hi;
		logic [8:0]  position;
		logic [7:0]  data_length, rec_type, sum;
		logic [15:0] offset;
		logic [7:0]  store[256];
		logic [19:0] seg_base;
		logic [15:0] lin_base;
		flash_word_t pending_words[$];
		int          mismatches;

		function new();
			win_lo = 32'h0;
			win_hi = ALL_ONES;
			prot_lo = ALL_ONES;
			prot_hi = 32'h0;
			position = '0;
			data_length = '0;
			rec_type = '0;
			sum = '0;
			offset = '0;
			seg_base = '0;
			lin_base = '0;
			mismatches = 0;
			foreach (store[i]) store[i] = 8'h00;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
			case (idx)
				REG_APP_BASE:     win_lo = value;
				REG_APP_END:      win_hi = value;
				REG_PROTECT_BASE: prot_lo = value;
				REG_PROTECT_END:  prot_hi = value;
				default: ;
			endcase
		endfunction

		function void owe(logic wv, logic [31:0] addr, logic [31:0] data, status_t st,
				logic fin);
			flash_word_t w;
			w.write_valid = wv;
			w.word_address = addr;
			w.word_data = data;
			w.status = st;
			w.record_kind = rec_type;
			w.last = fin;
			pending_words.push_back(w);
		endfunction

		// Bytes beyond the data length read as zero in base records.
		function logic [7:0] base_byte(int i);
			return (i < int'(data_length)) ? store[i] : 8'h00;
		endfunction

		// Works out the results of a record once its checksum byte is in.
		function void close_record();
			logic [31:0] addr, a, word;
			logic [32:0] top;
			int n;
			n = 0;
			if (int'(data_length) > MAX_DATA_BYTES || sum != 8'h00) begin
				owe(1'b0, '0, '0, STAT_CHECKSUM, 1'b1);
				return;
			end
			case (rec_type)
				REC_DATA: begin
					addr = {16'h0, offset} + {lin_base, 16'h0} + {12'h0, seg_base};
					top = {1'b0, addr} + 33'(data_length) - 33'd1;
					if (addr < win_lo || (data_length != 0 && top > {1'b0, win_hi})) begin
						owe(1'b0, '0, '0, STAT_WINDOW, 1'b1);
						return;
					end
					for (int k = 0; k < int'(data_length); k += 4) begin
						a = addr + 32'(k);
						if (a >= prot_lo && a <= prot_hi)
							continue;
						word = ALL_ONES;
						for (int b = 0; b < 4; b++)
							if (k + b < int'(data_length))
								word[8*b +: 8] = store[k + b];
						owe(1'b1, a, word, STAT_OK, 1'b0);
						n++;
					end
					if (n == 0)
						owe(1'b0, '0, '0, STAT_OK, 1'b1);
					else
						pending_words[pending_words.size() - 1].last = 1'b1;
					return;
				end
				REC_EOF: begin
					seg_base = '0;
					lin_base = '0;
				end
				REC_SEGMENT: begin
					seg_base = {base_byte(0), base_byte(1), 4'h0};
					lin_base = '0;
				end
				REC_LINEAR: begin
					lin_base = {base_byte(0), base_byte(1)};
					seg_base = '0;
				end
				default: begin
					owe(1'b0, '0, '0, STAT_TYPE, 1'b1);
					return;
				end
			endcase
			owe(1'b0, '0, '0, STAT_OK, 1'b1);
		endfunction

		// Notes one accepted byte of the record stream.
		function void take_byte(logic [7:0] b);
			int pos;
			pos = position;
			if (pos == 0)
				sum = 8'h00;
			sum = sum + b;
			if (pos == 0) begin
				data_length = b;
			end else if (pos == 1) begin
				offset = {b, 8'h00};
			end else if (pos == 2) begin
				offset[7:0] = b;
			end else if (pos == 3) begin
				rec_type = b;
			end else if (pos < int'(data_length) + 4) begin
				store[(pos - 4) & 255] = b;
			end else begin
				position = '0;
				close_record();
				return;
			end
			position = 9'(pos + 1);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s expected %h, got %h", $time, field, want, got);
			end
		endfunction

		// Checks one accepted result against the oldest word owed.
		function void check_word(flash_word_t got);
			flash_word_t want;
			if (pending_words.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected, got addr %h data %h status %0d",
					$time, got.word_address, got.word_data, got.status);
				return;
			end
			want = pending_words.pop_front();
			compare("write_valid", 32'(want.write_valid), 32'(got.write_valid));
			compare("word_address", want.word_address, got.word_address);
			compare("word_data", want.word_data, got.word_data);
			compare("status", 32'(want.status), 32'(got.status));
			compare("record_kind", 32'(want.record_kind), 32'(got.record_kind));
			compare("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ihex_byte_if rec_if();
	ihex_word_if word_if();
	ihex_cfg_if  cfg_if();

	flash_word_tracker tracker;
	bit      gaps_on;
	int      rx_hold;
	int      quiet_cycles;
	int      sent_bytes;

	intel_hex_record_loader_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec_in  (rec_if),
		.rec_out (word_if),
		.cfg     (cfg_if)
	);

	always #4 clk = ~clk;

	// Result side: check each accepted item, then stall at random in short bursts.
	always @(posedge clk) begin : result_side
		flash_word_t got;
		if (arst_n) begin
			if (word_if.valid && word_if.ready) begin
				got.write_valid = word_if.write_valid;
				got.word_address = word_if.word_address;
				got.word_data = word_if.word_data;
				got.status = status_t'(word_if.status);
				got.record_kind = word_if.record_kind;
				got.last = word_if.last;
				tracker.check_word(got);
			end
			if (rx_hold == 0 && gaps_on && $urandom_range(0, 7) == 0)
				rx_hold = $urandom_range(1, 3);
			if (rx_hold != 0) begin
				word_if.ready <= 1'b0;
				rx_hold--;
			end else begin
				word_if.ready <= 1'b1;
			end
		end else begin
			word_if.ready <= 1'b0;
		end
	end

	// Watchdog: end the run if no channel moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rec_if.valid && rec_if.ready) || (word_if.valid && word_if.ready) ||
					(cfg_if.valid && cfg_if.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	function automatic byte_q_t random_bytes(int n);
		byte_q_t q;
		for (int i = 0; i < n; i++)
			q.push_back(8'($urandom));
		return q;
	endfunction

	// Offers one byte, with an occasional gap ahead of it, and waits for acceptance.
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			rec_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec_if.valid <= 1'b1;
		rec_if.rec_byte <= b;
		@(posedge clk);
		while (!rec_if.ready)
			@(posedge clk);
		tracker.take_byte(b);
		sent_bytes++;
	endtask

	// Frames a whole record; a corrupted record gets a wrong checksum byte.
	task automatic send_record(input logic [7:0] kind, input logic [15:0] offs,
			input byte_q_t payload, input bit corrupt);
		byte_q_t frame;
		logic [7:0] csum;
		frame.push_back(8'(payload.size()));
		frame.push_back(offs[15:8]);
		frame.push_back(offs[7:0]);
		frame.push_back(kind);
		foreach (payload[i])
			frame.push_back(payload[i]);
		csum = 8'h00;
		foreach (frame[i])
			csum -= frame[i];
		if (corrupt)
			csum += 8'($urandom_range(1, 255));
		frame.push_back(csum);
		foreach (frame[i])
			push_byte(frame[i]);
	endtask

	// Holds the stream until every owed word has come and the loader has gone quiet.
	task automatic drain();
		rec_if.valid <= 1'b0;
		while (tracker.pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		tracker.write_reg(idx, value);
	endtask

	task automatic set_windows(input logic [31:0] app_lo, input logic [31:0] app_hi,
			input logic [31:0] guard_lo, input logic [31:0] guard_hi);
		drain();
		write_reg(REG_APP_BASE, app_lo);
		write_reg(REG_APP_END, app_hi);
		write_reg(REG_PROTECT_BASE, guard_lo);
		write_reg(REG_PROTECT_END, guard_hi);
		cfg_if.valid <= 1'b0;
	endtask

	// Mostly well-formed records with random content, the rest broken ones.
	task automatic random_record(input logic [15:0] lin_hint, input logic [15:0] offs_near);
		int pick, n, len;
		logic [7:0] kind;
		logic [15:0] offs;
		byte_q_t pl;
		bit corrupt;
		pick = $urandom_range(0, 99);
		corrupt = 1'b0;
		if ($urandom_range(0, 9) < 6)
			offs = offs_near + 16'($urandom_range(0, 127));
		else
			offs = 16'($urandom);
		n = $urandom_range(0, 9);
		len = (n == 0) ? 0 : (n == 1) ? 1 : (n == 2) ? 3 : 2;
		if (pick < 50) begin
			kind = REC_DATA;
			if ($urandom_range(0, 9) < 8)
				pl = random_bytes($urandom_range(0, 12));
			else
				pl = random_bytes($urandom_range(13, 40));
		end else if (pick < 60) begin
			kind = REC_LINEAR;
			pl = random_bytes(len);
			if ($urandom_range(0, 9) < 7) begin
				if (len > 0)
					pl[0] = lin_hint[15:8];
				if (len > 1)
					pl[1] = lin_hint[7:0];
			end
		end else if (pick < 67) begin
			kind = REC_SEGMENT;
			pl = random_bytes(len);
		end else if (pick < 72) begin
			kind = REC_EOF;
			pl = random_bytes(($urandom_range(0, 9) == 0) ? 2 : 0);
		end else if (pick < 82) begin
			kind = 8'($urandom);
			while (kind == REC_DATA || kind == REC_EOF || kind == REC_SEGMENT ||
					kind == REC_LINEAR)
				kind = 8'($urandom);
			pl = random_bytes($urandom_range(0, 6));
		end else begin
			kind = 8'($urandom_range(0, 5));
			pl = random_bytes($urandom_range(0, 8));
			corrupt = 1'b1;
		end
		send_record(kind, offs, pl, corrupt);
	endtask

	// One configuration setting: aim the linear base near the windows, then random records.
	task automatic run_phase(input logic [31:0] app_lo, input logic [31:0] app_hi,
			input logic [31:0] guard_lo, input logic [31:0] guard_hi,
			input logic [15:0] lin_hint, input logic [15:0] offs_near,
			input int budget, input bit with_gaps);
		int start;
		set_windows(app_lo, app_hi, guard_lo, guard_hi);
		gaps_on = with_gaps;
		send_record(REC_LINEAR, 16'h0000, '{lin_hint[15:8], lin_hint[7:0]}, 1'b0);
		start = sent_bytes;
		while (sent_bytes - start < budget) begin
			if (with_gaps)
				gaps_on = ($urandom_range(0, 3) != 0);
			random_record(lin_hint, offs_near);
			if ($urandom_range(0, 14) == 0)
				drain();
		end
	endtask

	initial begin
		tracker = new();
		rec_if.valid <= 1'b0;
		rec_if.rec_byte <= 8'h00;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_APP_BASE;
		cfg_if.data <= 32'h0;
		gaps_on = 1'b1;
		rx_hold = 0;
		quiet_cycles = 0;
		sent_bytes = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed records under the reset windows.
		send_record(REC_DATA, 16'h0000, random_bytes(0), 1'b0);
		send_record(REC_DATA, 16'hFFFF, '{8'hFF}, 1'b0);
		send_record(REC_DATA, 16'h1234, '{8'h00, 8'h11, 8'h22, 8'h33, 8'h44}, 1'b0);
		send_record(REC_EOF, 16'h0000, random_bytes(0), 1'b0);
		send_record(REC_SEGMENT, 16'h0000, '{8'hFF, 8'hFF}, 1'b0);
		send_record(REC_DATA, 16'hFFFF, '{8'h01, 8'h02, 8'h03, 8'h04}, 1'b0);
		// Short base records read the missing bytes as zero; extra bytes are ignored.
		send_record(REC_LINEAR, 16'h0000, '{8'hAB}, 1'b0);
		send_record(REC_SEGMENT, 16'h0000, random_bytes(0), 1'b0);
		send_record(REC_LINEAR, 16'h0000, '{8'hFF, 8'hFF, 8'h12}, 1'b0);
		// A record running past the top of the address space is out of window.
		send_record(REC_DATA, 16'hFFF8, random_bytes(16), 1'b0);
		send_record(8'h03, 16'h0000, '{8'h5A}, 1'b0);
		send_record(8'hFF, 16'h0000, random_bytes(0), 1'b0);
		send_record(REC_DATA, 16'h0010, '{8'hAA, 8'h55}, 1'b1);
		send_record(REC_EOF, 16'h0000, random_bytes(0), 1'b0);

		// Reset windows written back explicitly, with one record of the largest size.
		run_phase(32'h0, ALL_ONES, ALL_ONES, 32'h0, 16'h0000, 16'h0000, 8, 1'b1);
		send_record(REC_DATA, 16'h0100, random_bytes(MAX_DATA_BYTES), 1'b0);
		// Narrow application window with a protected block inside it.
		run_phase(32'h0001_0000, 32'h0001_FFFF, 32'h0001_0100, 32'h0001_013F,
			16'h0001, 16'h00E0, 10, 1'b1);
		// Everything protected: in-window data records produce no write.
		run_phase(32'h0, ALL_ONES, 32'h0, ALL_ONES, 16'h8000, 16'h0000, 8, 1'b1);
		// Window at the very top of the address space.
		run_phase(32'hFFFF_0000, ALL_ONES, 32'hFFFF_FF00, 32'hFFFF_FF7F,
			16'hFFFF, 16'hFFC0, 10, 1'b1);
		// Inverted window: only an empty record at the top address passes.
		run_phase(ALL_ONES, 32'h0, ALL_ONES, 32'h0, 16'hFFFF, 16'hFFF0, 6, 1'b1);
		// Closing stretch at full rate on both sides.
		run_phase(32'h0, ALL_ONES, ALL_ONES, 32'h0, 16'h0000, 16'h0000, 10, 1'b0);

		drain();
		if (tracker.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
